// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define POM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define POM_NEVER(label, cond, msg) \
   `POM_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/pom_pkg.sv =====
// Shared constants and types of the priority override mux.
package pom_pkg;

   localparam int NUM_SOURCES_DEF  = 4;
   localparam int NUM_CHANNELS_DEF = 18;
   localparam int AGE_BITS_DEF     = 16;

   localparam int WORD_BITS     = 16;
   localparam int PRIO_BITS     = 8;
   localparam int CH_BITS       = 5;
   localparam int NUM_PRIO_REGS = 4;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int JOBQ_DEPTH    = 2;
   localparam int OFIFO_DEPTH   = 4;

   localparam logic [WORD_BITS-1:0] TIMEOUT_RESET  = 16'd35;
   localparam logic [WORD_BITS-1:0] RELEASE_RESET  = 16'd0;
   localparam logic [WORD_BITS-1:0] NOCHANGE_RESET = 16'hFFFF;
   localparam logic [PRIO_BITS-1:0] PRIO_RESET [NUM_PRIO_REGS] =
      '{8'd100, 8'd90, 8'd80, 8'd70};

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_TICK    = 2'd1,
      OP_PUBLISH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_TIMEOUT  = 3'd0,
      REG_RELEASE  = 3'd1,
      REG_NOCHANGE = 3'd2,
      REG_PRIO0    = 3'd3,
      REG_PRIO1    = 3'd4,
      REG_PRIO2    = 3'd5,
      REG_PRIO3    = 3'd6
   } reg_index_type;

endpackage

// ===== rtl/pom_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pom_ram import pom_pkg::*; #(
   parameter int WIDTH = WORD_BITS,
   parameter int DEPTH = 2 * NUM_SOURCES_DEF * NUM_CHANNELS_DEF,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pom_jobq.sv =====
// Short FIFO of publish jobs between the front and back parts.
module pom_jobq import pom_pkg::*; #(
   parameter int WIDTH = 4,
   parameter int DEPTH = JOBQ_DEPTH,
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full     = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rptr_ff];

   // Advance pointers and count
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= data_in;
      end
   end

endmodule

// ===== rtl/pom_front.sv =====
// Front part: register port, source state, word writes and owner selection.
`include "assert_macros.svh"
module pom_front import pom_pkg::*; #(
   parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int AGE_BITS     = AGE_BITS_DEF,
   localparam int SRC_BITS  = $clog2(NUM_SOURCES),
   localparam int OWN_BITS  = $clog2(NUM_SOURCES + 1),
   localparam int JOB_BITS  = OWN_BITS + 1,
   localparam int ADDR_BITS = $clog2(2 * NUM_SOURCES * NUM_CHANNELS)
) (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_op,
   input  logic [SRC_BITS-1:0]      req_source,
   input  logic [CH_BITS-1:0]       req_channel,
   input  logic [WORD_BITS-1:0]     req_value,
   input  logic                     req_frame_end,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   // word store write port
   output logic                     mem_wr_en,
   output logic [ADDR_BITS-1:0]     mem_wr_addr,
   output logic [WORD_BITS-1:0]     mem_wr_data,
   // job queue
   output logic                     jobq_push,
   output logic [JOB_BITS-1:0]      jobq_data,
   input  logic                     jobq_full,
   // job retired by the back part
   input  logic                     done_valid,
   input  logic [JOB_BITS-1:0]      done_job,
   output logic [WORD_BITS-1:0]     release_code
);

   localparam int CMP_BITS  = (AGE_BITS > WORD_BITS) ? AGE_BITS : WORD_BITS;
   localparam int LOCK_BITS = $clog2(JOBQ_DEPTH + 2);

   // configuration registers
   logic [WORD_BITS-1:0] timeout_ff, timeout_in;
   logic [WORD_BITS-1:0] release_ff, release_in;
   logic [WORD_BITS-1:0] nochange_ff, nochange_in;
   logic [PRIO_BITS-1:0] prio_ff [NUM_PRIO_REGS];
   logic [PRIO_BITS-1:0] prio_in [NUM_PRIO_REGS];

   // per-source state
   logic                 bank_ff   [NUM_SOURCES];
   logic                 bank_in   [NUM_SOURCES];
   logic                 seen_ff   [NUM_SOURCES];
   logic                 seen_in   [NUM_SOURCES];
   logic                 claims_ff [NUM_SOURCES];
   logic                 claims_in [NUM_SOURCES];
   logic                 pend_ff   [NUM_SOURCES];
   logic                 pend_in   [NUM_SOURCES];
   logic [AGE_BITS-1:0]  age_ff    [NUM_SOURCES];
   logic [AGE_BITS-1:0]  age_in    [NUM_SOURCES];
   logic [LOCK_BITS-1:0] lock_ff   [NUM_SOURCES][2];
   logic [LOCK_BITS-1:0] lock_in   [NUM_SOURCES][2];

   op_type              op;
   reg_index_type       csr_idx;
   logic                csr_wr;
   logic                accept, src_ok, ch_ok, tgt_bank, tgt_locked, word_claims;
   logic                is_write, word_write, commit, tick, publish;
   logic [OWN_BITS-1:0] sel;
   logic                sel_ok, sel_bank;
   logic [OWN_BITS-1:0] done_owner;
   logic                done_bank;

   assign op      = op_type'(req_op);
   assign csr_idx = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;

   // Classify the waiting item
   assign src_ok      = (int'(req_source) < NUM_SOURCES);
   assign ch_ok       = (int'(req_channel) < NUM_CHANNELS);
   assign tgt_bank    = ~bank_ff[req_source];
   assign tgt_locked  = (lock_ff[req_source][tgt_bank] != '0);
   assign word_claims = (req_value != release_ff) && (req_value != nochange_ff);

   // Hold a publish on a full job queue, a word write on a bank being read
   always_comb begin
      case (op)
         OP_WRITE:   full = src_ok && ch_ok && tgt_locked;
         OP_PUBLISH: full = jobq_full;
         default:    full = 1'b0;
      endcase
   end

   assign accept     = push && !full;
   assign is_write   = accept && (op == OP_WRITE) && src_ok;
   assign word_write = is_write && ch_ok;
   assign commit     = is_write && req_frame_end;
   assign tick       = accept && (op == OP_TICK);
   assign publish    = accept && (op == OP_PUBLISH);

   // Write the word into the shadow bank
   assign mem_wr_en   = word_write;
   assign mem_wr_addr = ADDR_BITS'((2 * int'(req_source) + int'(tgt_bank)) * NUM_CHANNELS
                                   + int'(req_channel));
   assign mem_wr_data = req_value;

   // Pick the fresh claiming source with the highest priority, lower index on a tie
   always_comb begin
      logic                 elig;
      logic [PRIO_BITS-1:0] prio;
      logic [PRIO_BITS-1:0] best;
      sel  = OWN_BITS'(NUM_SOURCES);
      best = '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         elig = seen_ff[s] && claims_ff[s] &&
                !(CMP_BITS'(age_ff[s]) > CMP_BITS'(timeout_ff));
         prio = (s < NUM_PRIO_REGS) ? prio_ff[s % NUM_PRIO_REGS] : '0;
         if (elig && ((sel == OWN_BITS'(NUM_SOURCES)) || (prio > best))) begin
            sel  = OWN_BITS'(s);
            best = prio;
         end
      end
   end

   assign sel_ok    = (sel != OWN_BITS'(NUM_SOURCES));
   assign sel_bank  = sel_ok ? bank_ff[sel[SRC_BITS-1:0]] : 1'b0;
   assign jobq_push = publish;
   assign jobq_data = {sel, sel_bank};

   assign done_owner = done_job[JOB_BITS-1:1];
   assign done_bank  = done_job[0];

   // Update source state: commit, age and bank locks
   always_comb begin
      logic hit, inc, dec;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         hit          = is_write && (int'(req_source) == s);
         bank_in[s]   = bank_ff[s];
         seen_in[s]   = seen_ff[s];
         claims_in[s] = claims_ff[s];
         pend_in[s]   = pend_ff[s];
         age_in[s]    = age_ff[s];
         if (hit && commit) begin
            bank_in[s]   = ~bank_ff[s];
            seen_in[s]   = 1'b1;
            claims_in[s] = pend_ff[s] || (ch_ok && word_claims);
            pend_in[s]   = 1'b0;
            age_in[s]    = '0;
         end else if (hit && ch_ok && word_claims) begin
            pend_in[s] = 1'b1;
         end else if (tick && (age_ff[s] != '1)) begin
            age_in[s] = age_ff[s] + 1'b1;
         end
         for (int b = 0; b < 2; b++) begin
            inc = publish && sel_ok && (int'(sel) == s) && (int'(sel_bank) == b);
            dec = done_valid && (int'(done_owner) == s) && (int'(done_bank) == b);
            lock_in[s][b] = lock_ff[s][b] + LOCK_BITS'(inc) - LOCK_BITS'(dec);
         end
      end
   end

   // Write configuration registers
   always_comb begin
      timeout_in  = timeout_ff;
      release_in  = release_ff;
      nochange_in = nochange_ff;
      prio_in     = prio_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_TIMEOUT:  timeout_in  = pwdata[WORD_BITS-1:0];
            REG_RELEASE:  release_in  = pwdata[WORD_BITS-1:0];
            REG_NOCHANGE: nochange_in = pwdata[WORD_BITS-1:0];
            REG_PRIO0:    prio_in[0]  = pwdata[PRIO_BITS-1:0];
            REG_PRIO1:    prio_in[1]  = pwdata[PRIO_BITS-1:0];
            REG_PRIO2:    prio_in[2]  = pwdata[PRIO_BITS-1:0];
            REG_PRIO3:    prio_in[3]  = pwdata[PRIO_BITS-1:0];
            default:      timeout_in  = timeout_ff;
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      case (csr_idx)
         REG_TIMEOUT:  prdata = CSR_DATA_BITS'(timeout_ff);
         REG_RELEASE:  prdata = CSR_DATA_BITS'(release_ff);
         REG_NOCHANGE: prdata = CSR_DATA_BITS'(nochange_ff);
         REG_PRIO0:    prdata = CSR_DATA_BITS'(prio_ff[0]);
         REG_PRIO1:    prdata = CSR_DATA_BITS'(prio_ff[1]);
         REG_PRIO2:    prdata = CSR_DATA_BITS'(prio_ff[2]);
         REG_PRIO3:    prdata = CSR_DATA_BITS'(prio_ff[3]);
         default:      prdata = '0;
      endcase
   end

   assign release_code = release_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         release_ff  <= RELEASE_RESET;
         nochange_ff <= NOCHANGE_RESET;
         prio_ff     <= PRIO_RESET;
         for (int s = 0; s < NUM_SOURCES; s++) begin
            bank_ff[s]    <= 1'b0;
            seen_ff[s]    <= 1'b0;
            claims_ff[s]  <= 1'b0;
            pend_ff[s]    <= 1'b0;
            age_ff[s]     <= '0;
            lock_ff[s][0] <= '0;
            lock_ff[s][1] <= '0;
         end
      end else begin
         timeout_ff  <= timeout_in;
         release_ff  <= release_in;
         nochange_ff <= nochange_in;
         prio_ff     <= prio_in;
         bank_ff     <= bank_in;
         seen_ff     <= seen_in;
         claims_ff   <= claims_in;
         pend_ff     <= pend_in;
         age_ff      <= age_in;
         lock_ff     <= lock_in;
      end
   end

   // A bank lock counts queued plus running jobs and must never wrap
   `POM_NEVER(a_lock_no_wrap, publish && sel_ok && (lock_ff[sel[SRC_BITS-1:0]][sel_bank] == '1), "bank lock counter wraps")
   // A retired job always has a lock to release
   `POM_NEVER(a_lock_no_underflow, done_valid && (done_owner != OWN_BITS'(NUM_SOURCES)) && (lock_ff[done_owner[SRC_BITS-1:0]][done_bank] == '0), "bank lock released twice")

endmodule

// ===== rtl/pom_back.sv =====
// Back part: walks a publish job over the channels and queues the result beats.
`include "assert_macros.svh"
module pom_back import pom_pkg::*; #(
   parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   localparam int OWN_BITS  = $clog2(NUM_SOURCES + 1),
   localparam int JOB_BITS  = OWN_BITS + 1,
   localparam int ADDR_BITS = $clog2(2 * NUM_SOURCES * NUM_CHANNELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   // job queue
   input  logic                 jobq_empty,
   input  logic [JOB_BITS-1:0]  jobq_data,
   output logic                 jobq_pop,
   input  logic [WORD_BITS-1:0] release_code,
   // word store read port
   output logic                 mem_rd_en,
   output logic [ADDR_BITS-1:0] mem_rd_addr,
   input  logic [WORD_BITS-1:0] mem_rd_data,
   // job retired
   output logic                 done_valid,
   output logic [JOB_BITS-1:0]  done_job,
   // result channel
   output logic                 empty,
   input  logic                 pop,
   output logic [CH_BITS-1:0]   rsp_out_channel,
   output logic [WORD_BITS-1:0] rsp_out_value,
   output logic [OWN_BITS-1:0]  rsp_owner,
   output logic                 rsp_run_last
);

   localparam int PTR_BITS = $clog2(OFIFO_DEPTH);
   localparam int CNT_BITS = $clog2(OFIFO_DEPTH + 1);

   typedef struct packed {
      logic [CH_BITS-1:0]   ch;
      logic [WORD_BITS-1:0] value;
      logic [OWN_BITS-1:0]  owner;
      logic                 last;
   } rsp_type;

   // current job
   logic                cur_valid_ff, cur_valid_in;
   logic [JOB_BITS-1:0] cur_job_ff, cur_job_in;
   logic [CH_BITS-1:0]  ch_ff, ch_in;
   logic [OWN_BITS-1:0] cur_owner;
   logic                cur_bank, cur_none, load, issue, ch_last, space;

   // read stage
   logic                rd_valid_ff;
   logic [CH_BITS-1:0]  rd_ch_ff;
   logic [OWN_BITS-1:0] rd_owner_ff;
   logic                rd_none_ff, rd_last_ff;

   // result FIFO
   rsp_type             ent_ff [OFIFO_DEPTH];
   rsp_type             ent_wr, ent_head;
   logic [PTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                ofifo_wr, ofifo_rd;

   assign cur_owner = cur_job_ff[JOB_BITS-1:1];
   assign cur_bank  = cur_job_ff[0];
   assign cur_none  = (cur_owner == OWN_BITS'(NUM_SOURCES));
   assign ch_last   = (ch_ff == CH_BITS'(NUM_CHANNELS - 1));

   // Take a job when idle, issue a read while the FIFO has room for it
   assign load     = !cur_valid_ff && !jobq_empty;
   assign jobq_pop = load;
   assign space    = ((CNT_BITS + 1)'(cnt_ff) + (CNT_BITS + 1)'(rd_valid_ff))
                     < (CNT_BITS + 1)'(OFIFO_DEPTH);
   assign issue    = cur_valid_ff && space;

   assign mem_rd_en   = issue && !cur_none;
   assign mem_rd_addr = ADDR_BITS'((2 * int'(cur_owner) + int'(cur_bank)) * NUM_CHANNELS
                                   + int'(ch_ff));

   assign done_valid = issue && ch_last;
   assign done_job   = cur_job_ff;

   // Advance the channel walk
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      ch_in        = ch_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         cur_job_in   = jobq_data;
         ch_in        = '0;
      end else if (issue) begin
         ch_in = ch_last ? '0 : ch_ff + 1'b1;
         if (ch_last) begin
            cur_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         ch_ff        <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         ch_ff        <= ch_in;
         rd_valid_ff  <= issue;
      end
   end

   // Carry beat data alongside the read
   always_ff @(posedge clock) begin
      cur_job_ff <= cur_job_in;
      if (issue) begin
         rd_ch_ff    <= ch_ff;
         rd_owner_ff <= cur_owner;
         rd_none_ff  <= cur_none;
         rd_last_ff  <= ch_last;
      end
   end

   // Fill with the release code when no source owns the output
   assign ofifo_wr     = rd_valid_ff;
   assign ent_wr.ch    = rd_ch_ff;
   assign ent_wr.value = rd_none_ff ? release_code : mem_rd_data;
   assign ent_wr.owner = rd_owner_ff;
   assign ent_wr.last  = rd_last_ff;

   assign empty    = (cnt_ff == '0);
   assign ofifo_rd = pop && !empty;
   assign ent_head = ent_ff[rptr_ff];

   assign rsp_out_channel = ent_head.ch;
   assign rsp_out_value   = ent_head.value;
   assign rsp_owner       = ent_head.owner;
   assign rsp_run_last    = ent_head.last;

   // Advance FIFO pointers
   always_comb begin
      wptr_in = ofifo_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = ofifo_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (ofifo_wr && !ofifo_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (ofifo_rd && !ofifo_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ofifo_wr) begin
         ent_ff[wptr_ff] <= ent_wr;
      end
   end

   // The room check must keep the FIFO from overflowing
   `POM_NEVER(a_ofifo_no_overflow, ofifo_wr && !ofifo_rd && (cnt_ff == CNT_BITS'(OFIFO_DEPTH)), "result FIFO overflow")
   // The run_last beat carries the final channel
   `POM_ASSERT(a_last_is_final_ch, (!empty && rsp_run_last) |-> (rsp_out_channel == CH_BITS'(NUM_CHANNELS - 1)), "run_last on wrong channel")

endmodule

// ===== rtl/priority_override_mux_core.sv =====
// Top level of the priority override mux: front, job queue, back and word store.
//
//  channel   direction  handshake              payload
//  request   in         push / full           req_op req_source req_channel req_value
//                                              req_frame_end
//  response  out        empty / pop            rsp_out_channel rsp_out_value rsp_owner
//                                              rsp_run_last
//  config    in         psel penable pwrite    paddr pwdata prdata (pready tied high)
//
//  Word writes, ticks and publishes are each taken when push is high and full is low.
//  A publish yields NUM_CHANNELS beats, one per cycle from the word store read port
//  while the result FIFO has room; the back part first loads each job from the job queue.
//  A publish waits while the two-entry job queue is full; a word write waits while a
//  queued or running job still reads the bank it targets.
//  The word store needs no clearing pass at reset.
`include "assert_macros.svh"
module priority_override_mux_core import pom_pkg::*; #(
   parameter int NUM_SOURCES  = NUM_SOURCES_DEF,
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int AGE_BITS     = AGE_BITS_DEF,
   localparam int SRC_BITS   = $clog2(NUM_SOURCES),
   localparam int OWN_BITS   = $clog2(NUM_SOURCES + 1),
   localparam int JOB_BITS   = OWN_BITS + 1,
   localparam int STORE_SIZE = 2 * NUM_SOURCES * NUM_CHANNELS,
   localparam int ADDR_BITS  = $clog2(STORE_SIZE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [1:0]               req_op,
   input  logic [SRC_BITS-1:0]      req_source,
   input  logic [CH_BITS-1:0]       req_channel,
   input  logic [WORD_BITS-1:0]     req_value,
   input  logic                     req_frame_end,
   output logic                     empty,
   input  logic                     pop,
   output logic [CH_BITS-1:0]       rsp_out_channel,
   output logic [WORD_BITS-1:0]     rsp_out_value,
   output logic [OWN_BITS-1:0]      rsp_owner,
   output logic                     rsp_run_last,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic                 mem_wr_en, mem_rd_en;
   logic [ADDR_BITS-1:0] mem_wr_addr, mem_rd_addr;
   logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;
   logic                 jobq_push, jobq_full, jobq_pop, jobq_empty;
   logic [JOB_BITS-1:0]  jobq_in, jobq_out;
   logic                 done_valid;
   logic [JOB_BITS-1:0]  done_job;
   logic [WORD_BITS-1:0] release_code;

   pom_front #(
      .NUM_SOURCES  (NUM_SOURCES),
      .NUM_CHANNELS (NUM_CHANNELS),
      .AGE_BITS     (AGE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_source    (req_source),
      .req_channel   (req_channel),
      .req_value     (req_value),
      .req_frame_end (req_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .jobq_push     (jobq_push),
      .jobq_data     (jobq_in),
      .jobq_full     (jobq_full),
      .done_valid    (done_valid),
      .done_job      (done_job),
      .release_code  (release_code)
   );

   pom_jobq #(
      .WIDTH (JOB_BITS),
      .DEPTH (JOBQ_DEPTH)
   ) u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (jobq_push),
      .data_in  (jobq_in),
      .full     (jobq_full),
      .pop      (jobq_pop),
      .data_out (jobq_out),
      .empty    (jobq_empty)
   );

   pom_back #(
      .NUM_SOURCES  (NUM_SOURCES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .jobq_empty      (jobq_empty),
      .jobq_data       (jobq_out),
      .jobq_pop        (jobq_pop),
      .release_code    (release_code),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .done_valid      (done_valid),
      .done_job        (done_job),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_value   (rsp_out_value),
      .rsp_owner       (rsp_owner),
      .rsp_run_last    (rsp_run_last)
   );

   pom_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Bank locking keeps a shadow write off the bank being published
   `POM_NEVER(a_no_rw_clash, mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr), "word store write hits the published bank")

endmodule

// ===== tb/priority_override_mux_core_tb.sv =====
// Testbench for the priority override mux: random frames, ticks and publishes against a predictor.
`timescale 1ns / 100ps

module priority_override_mux_core_tb;
   import pom_pkg::*;

   localparam int NUM_SRC      = NUM_SOURCES_DEF;
   localparam int NUM_CH       = NUM_CHANNELS_DEF;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]           op;
      logic [1:0]           source;
      logic [CH_BITS-1:0]   channel;
      logic [WORD_BITS-1:0] value;
      logic                 frame_end;
   } mux_request_type;

   typedef struct packed {
      logic [CH_BITS-1:0]   channel;
      logic [WORD_BITS-1:0] value;
      logic [2:0]           owner;
      logic                 last;
   } mux_beat_type;

   // Predict the published beats from the accepted requests and the register values.
   class override_mux_model_type;
      logic [WORD_BITS-1:0] stale_limit;
      logic [WORD_BITS-1:0] release_word;
      logic [WORD_BITS-1:0] nochange_word;
      logic [PRIO_BITS-1:0] prio [NUM_SRC];
      logic [WORD_BITS-1:0] words [NUM_SRC][2][NUM_CH];
      bit                   filled [NUM_SRC][2][NUM_CH];
      bit                   live_bank [NUM_SRC];
      bit                   seen [NUM_SRC];
      logic [WORD_BITS-1:0] age [NUM_SRC];
      bit                   claims [NUM_SRC];
      bit                   claim_acc [NUM_SRC];
      mux_beat_type         expected_beats [$];
      int                   errors;

      function new();
         stale_limit   = TIMEOUT_RESET;
         release_word  = RELEASE_RESET;
         nochange_word = NOCHANGE_RESET;
         for (int s = 0; s < NUM_SRC; s++) begin
            prio[s]      = PRIO_RESET[s];
            live_bank[s] = 1'b0;
            seen[s]      = 1'b0;
            age[s]       = '0;
            claims[s]    = 1'b0;
            claim_acc[s] = 1'b0;
            for (int b = 0; b < 2; b++)
               for (int c = 0; c < NUM_CH; c++) begin
                  words[s][b][c]  = '0;
                  filled[s][b][c] = 1'b0;
               end
         end
         errors = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_TIMEOUT:  stale_limit   = data[WORD_BITS-1:0];
            REG_RELEASE:  release_word  = data[WORD_BITS-1:0];
            REG_NOCHANGE: nochange_word = data[WORD_BITS-1:0];
            REG_PRIO0:    prio[0]       = data[PRIO_BITS-1:0];
            REG_PRIO1:    prio[1]       = data[PRIO_BITS-1:0];
            REG_PRIO2:    prio[2]       = data[PRIO_BITS-1:0];
            REG_PRIO3:    prio[3]       = data[PRIO_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Fresh, seen, claiming source of highest priority; ties go to the lower index.
      function int pick_owner();
         int sel;
         sel = NUM_SRC;
         for (int s = 0; s < NUM_SRC; s++) begin
            if (!seen[s] || age[s] > stale_limit || !claims[s])
               continue;
            if (sel == NUM_SRC || prio[s] > prio[sel])
               sel = s;
         end
         return sel;
      endfunction

      // A publish must never read a word that was never written in the active bank.
      function bit publish_ok();
         int sel;
         sel = pick_owner();
         if (sel == NUM_SRC)
            return 1'b1;
         for (int c = 0; c < NUM_CH; c++)
            if (!filled[sel][live_bank[sel]][c])
               return 1'b0;
         return 1'b1;
      endfunction

      function void take_request(mux_request_type r);
         int           sel;
         bit           shadow;
         mux_beat_type b;
         case (r.op)
            OP_WRITE: begin
               shadow = ~live_bank[r.source];
               // drop words beyond the last channel
               if (r.channel < NUM_CH) begin
                  words[r.source][shadow][r.channel]  = r.value;
                  filled[r.source][shadow][r.channel] = 1'b1;
                  if (r.value != release_word && r.value != nochange_word)
                     claim_acc[r.source] = 1'b1;
               end
               if (r.frame_end) begin
                  live_bank[r.source] = shadow;
                  claims[r.source]    = claim_acc[r.source];
                  claim_acc[r.source] = 1'b0;
                  seen[r.source]      = 1'b1;
                  age[r.source]       = '0;
               end
            end
            OP_TICK: begin
               // hold ages at their maximum
               for (int s = 0; s < NUM_SRC; s++)
                  if (age[s] != '1)
                     age[s] = age[s] + 1'b1;
            end
            OP_PUBLISH: begin
               sel = pick_owner();
               for (int c = 0; c < NUM_CH; c++) begin
                  b.channel = CH_BITS'(c);
                  b.value   = (sel == NUM_SRC) ? release_word : words[sel][live_bank[sel]][c];
                  b.owner   = 3'(sel);
                  b.last    = (c == NUM_CH - 1);
                  expected_beats.push_back(b);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_beat(mux_beat_type got);
         mux_beat_type exp_b;
         if (expected_beats.size() == 0) begin
            $display("%0t: beat with nothing expected: channel %0d value %h owner %0d last %0b",
                     $time, got.channel, got.value, got.owner, got.last);
            errors++;
            return;
         end
         exp_b = expected_beats.pop_front();
         if (got.channel !== exp_b.channel) begin
            $display("%0t: out_channel expected %0d actual %0d", $time, exp_b.channel, got.channel);
            errors++;
         end
         if (got.value !== exp_b.value) begin
            $display("%0t: out_value expected %h actual %h (channel %0d)",
                     $time, exp_b.value, got.value, exp_b.channel);
            errors++;
         end
         if (got.owner !== exp_b.owner) begin
            $display("%0t: owner expected %0d actual %0d (channel %0d)",
                     $time, exp_b.owner, got.owner, exp_b.channel);
            errors++;
         end
         if (got.last !== exp_b.last) begin
            $display("%0t: run_last expected %0b actual %0b (channel %0d)",
                     $time, exp_b.last, got.last, exp_b.channel);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset         = 1'b1;
   logic                     push          = 1'b0;
   logic                     full;
   logic [1:0]               req_op        = '0;
   logic [1:0]               req_source    = '0;
   logic [CH_BITS-1:0]       req_channel   = '0;
   logic [WORD_BITS-1:0]     req_value     = '0;
   logic                     req_frame_end = 1'b0;
   logic                     empty;
   logic                     pop           = 1'b0;
   logic [CH_BITS-1:0]       rsp_out_channel;
   logic [WORD_BITS-1:0]     rsp_out_value;
   logic [2:0]               rsp_owner;
   logic                     rsp_run_last;
   logic                     psel          = 1'b0;
   logic                     penable       = 1'b0;
   logic                     pwrite        = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr         = '0;
   logic [CSR_DATA_BITS-1:0] pwdata        = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   override_mux_model_type model = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int sent_count     = 0;
   int cycle_count    = 0;

   priority_override_mux_core u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_source      (req_source),
      .req_channel     (req_channel),
      .req_value       (req_value),
      .req_frame_end   (req_frame_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_channel (rsp_out_channel),
      .rsp_out_value   (rsp_out_value),
      .rsp_owner       (rsp_owner),
      .rsp_run_last    (rsp_run_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Check each result beat and stall the result side at random.
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         model.check_beat(mux_beat_type'{rsp_out_channel, rsp_out_value, rsp_owner,
                                         rsp_run_last});
      pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      model.write_reg(idx, data);
   endtask

   // Send one request beat; an unsafe publish turns into a tick.
   task automatic send_request(input logic [1:0] op, input int src, input int ch,
                               input logic [WORD_BITS-1:0] val, input bit fend);
      mux_request_type r;
      if (op == OP_PUBLISH && !model.publish_ok())
         op = OP_TICK;
      r = '{op, 2'(src), CH_BITS'(ch), val, fend};
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_op        <= r.op;
      req_source    <= r.source;
      req_channel   <= r.channel;
      req_value     <= r.value;
      req_frame_end <= r.frame_end;
      do @(posedge clock); while (full);
      model.take_request(r);
      if (op != OP_UNUSED)
         sent_count++;
   endtask

   // Ticks and publishes carry random junk in the unused fields.
   task automatic send_control(input logic [1:0] op);
      send_request(op, $urandom_range(3), $urandom_range(31), 16'($urandom),
                   1'($urandom_range(1)));
   endtask

   function automatic logic [WORD_BITS-1:0] pick_word(input bit quiet);
      int r;
      r = $urandom_range(9);
      if (r < 4)
         return model.release_word;
      if (quiet || r < 7)
         return model.nochange_word;
      if (r == 7)
         return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return 16'($urandom);
   endfunction

   task automatic send_frame(input int src, input bit quiet);
      for (int c = 0; c < NUM_CH; c++)
         send_request(OP_WRITE, src, c, pick_word(quiet), c == NUM_CH - 1);
   endtask

   // Short frame with stray channels; it may or may not commit.
   task automatic send_broken_frame(input int src);
      int len;
      bit commit;
      len    = $urandom_range(1, NUM_CH - 1);
      commit = ($urandom_range(9) < 7);
      for (int i = 0; i < len; i++)
         send_request(OP_WRITE, src, $urandom_range(31), pick_word(1'b0),
                      commit && (i == len - 1));
   endtask

   task automatic run_mix(input int budget);
      int start;
      int pick;
      int n;
      start = sent_count;
      while (sent_count - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_frame($urandom_range(3), $urandom_range(3) == 0);
         else if (pick < 50)
            send_broken_frame($urandom_range(3));
         else if (pick < 68) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 6);
            repeat (n) send_control(OP_TICK);
         end
         else if (pick < 95)
            send_control(OP_PUBLISH);
         else
            send_control(OP_UNUSED);
      end
   endtask

   // Drop push, drain every expected beat and let the block go idle.
   task automatic settle();
      push <= 1'b0;
      while (model.expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, no idling: empty publishes, ignored op, empty and dropped commits.
      send_control(OP_PUBLISH);
      send_request(OP_UNUSED, 3, 31, 16'hFFFF, 1'b1);
      send_request(OP_WRITE, 3, 31, 16'hFFFF, 1'b1);
      send_control(OP_TICK);
      send_control(OP_PUBLISH);
      send_request(OP_WRITE, 2, 0, 16'h0000, 1'b0);
      send_request(OP_WRITE, 2, NUM_CH - 1, 16'hFFFF, 1'b0);
      send_request(OP_WRITE, 2, NUM_CH, 16'h8001, 1'b1);
      send_control(OP_PUBLISH);
      run_mix(30);
      settle();

      // Zero timeout, swapped codes, tied top priorities; sender idles.
      csr_write(REG_TIMEOUT, 32'd0);
      csr_write(REG_RELEASE, 32'hFFFF);
      csr_write(REG_NOCHANGE, 32'h0000);
      csr_write(REG_PRIO0, 32'd255);
      csr_write(REG_PRIO1, 32'd0);
      csr_write(REG_PRIO2, 32'd255);
      csr_write(REG_PRIO3, 32'd0);
      send_idle_pct = 69;
      run_mix(30);
      settle();

      // Short timeout, random codes, all priorities zero; receiver stalls.
      csr_write(REG_TIMEOUT, 32'd12);
      csr_write(REG_RELEASE, 32'($urandom_range(65535)));
      csr_write(REG_NOCHANGE, 32'($urandom_range(65535)));
      csr_write(REG_PRIO0, 32'd0);
      csr_write(REG_PRIO1, 32'd0);
      csr_write(REG_PRIO2, 32'd0);
      csr_write(REG_PRIO3, 32'd0);
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      run_mix(30);
      settle();

      // Equal release and no-change codes, random priorities; both sides idle.
      csr_write(REG_TIMEOUT, 32'($urandom_range(20, 50)));
      csr_write(REG_RELEASE, 32'h1234);
      csr_write(REG_NOCHANGE, 32'h1234);
      csr_write(REG_PRIO0, 32'($urandom_range(255)));
      csr_write(REG_PRIO1, 32'($urandom_range(255)));
      csr_write(REG_PRIO2, 32'($urandom_range(255)));
      csr_write(REG_PRIO3, 32'($urandom_range(255)));
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      run_mix(30);
      settle();

      if (model.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
